// ===== hw/rtl/vdq_pkg.sv =====
package vdq_pkg;

    localparam int VDQ_COORD_BITS   = 16;
    localparam int VDQ_FIELD_BITS   = VDQ_COORD_BITS;
    localparam int VDQ_EXT_BITS     = 32;
    localparam int VDQ_QUEUE_DEPTH  = 4;
    localparam int VDQ_FRAC_BITS    = 48;
    localparam int VDQ_HALF_BITS    = VDQ_FRAC_BITS / 2;
    localparam int VDQ_NUM_THRESH   = 32;
    localparam int VDQ_TIDX_BITS    = $clog2(VDQ_NUM_THRESH);
    localparam int VDQ_CNT_BITS     = $clog2(VDQ_NUM_THRESH + 1);
    localparam int VDQ_SEARCH_STEPS = VDQ_TIDX_BITS + 1;
    localparam int VDQ_FINE_BITS    = 8;
    localparam int VDQ_COARSE_BITS  = 3;
    localparam int VDQ_TURN_BITS    = VDQ_FINE_BITS + 1;
    localparam int VDQ_SERIES_TERMS = 14;
    localparam int VDQ_STEP_SHIFT   = 8;
    localparam int VDQ_Q_BITS       = 62;

    localparam logic [63:0] VDQ_PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] VDQ_ONE_Q62 = 64'h4000000000000000;

    localparam logic [VDQ_TURN_BITS-1:0] VDQ_OCTANT_STEPS = 9'd64;
    localparam logic [VDQ_TURN_BITS-1:0] VDQ_HALF_TURN    = 9'd128;
    localparam logic [VDQ_TURN_BITS-1:0] VDQ_FULL_TURN    = 9'd256;
    localparam logic [VDQ_FINE_BITS-1:0] VDQ_COARSE_BIAS  = 8'd16;

    typedef struct packed {
        logic [VDQ_FIELD_BITS-1:0] start_x;
        logic [VDQ_FIELD_BITS-1:0] start_y;
        logic [VDQ_FIELD_BITS-1:0] end_x;
        logic [VDQ_FIELD_BITS-1:0] end_y;
    } t_vdq_in;

    typedef struct packed {
        logic [VDQ_FINE_BITS-1:0]   facing_fine;
        logic [VDQ_COARSE_BITS-1:0] facing_coarse;
    } t_vdq_out;

    typedef struct packed {
        logic zero;
        logic swap;
        logic neg_x;
        logic neg_y;
    } t_vdq_flags;

    typedef logic [VDQ_NUM_THRESH-1:0][VDQ_FRAC_BITS-1:0] t_vdq_tan_rom;

    function automatic logic [63:0] vdq_qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[VDQ_Q_BITS+63:VDQ_Q_BITS];
    endfunction

    function automatic logic [63:0] vdq_udiv(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] rem;
        logic [63:0]  q;
        rem = '0;
        q   = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[126:0], n[i]};
            q   = {q[62:0], 1'b0};
            if (rem >= {64'd0, d}) begin
                rem  = rem - {64'd0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // tan((2k+1)*pi/256) by series for sine and cosine, then a long division
    function automatic t_vdq_tan_rom vdq_build_tan();
        t_vdq_tan_rom rom;
        logic [63:0]  step;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  st;
        logic [63:0]  s;
        logic [63:0]  ct;
        logic [63:0]  c;
        logic [63:0]  q;
        logic [63:0]  t;
        logic [127:0] num;
        rom  = '0;
        step = VDQ_PI_Q62 >> VDQ_STEP_SHIFT;
        for (int k = 0; k < VDQ_NUM_THRESH; k++) begin
            x  = step * 64'(2 * k + 1);
            x2 = vdq_qmul(x, x);
            st = x;
            s  = x;
            ct = VDQ_ONE_Q62;
            c  = VDQ_ONE_Q62;
            for (int n = 1; n <= VDQ_SERIES_TERMS; n++) begin
                st = vdq_udiv({64'd0, vdq_qmul(st, x2)}, 64'((2 * n) * (2 * n + 1)));
                ct = vdq_udiv({64'd0, vdq_qmul(ct, x2)}, 64'((2 * n - 1) * (2 * n)));
                if (n[0]) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            num    = {64'd0, s} << (VDQ_FRAC_BITS + 1);
            q      = vdq_udiv(num, c);
            t      = (q + 64'd1) >> 1;
            rom[k] = t[VDQ_FRAC_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_vdq_tan_rom VDQ_TAN = vdq_build_tan();

endpackage

// ===== hw/rtl/vector_direction_quantizer_core.sv =====
// throughput: one transfer per cycle unless either side stalls; a 6-step
// threshold search, two pipeline stages per step with one split multiply
// each, sits behind a short queue and ahead of an output register
// reset: synchronous, active low; clears stage valid flags and queue pointers,
// the threshold table is constant and needs no fill
module vector_direction_quantizer_core #(
    parameter int QUEUE_DEPTH = vdq_pkg::VDQ_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  vdq_pkg::t_vdq_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output vdq_pkg::t_vdq_out o_out_data,
    input  logic              i_out_stall
);

    import vdq_pkg::*;

    localparam int DW = VDQ_COORD_BITS + 1;
    localparam int QW = 2 * DW + $bits(t_vdq_flags);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [DW-1:0] f_lo;
    logic [DW-1:0] f_hi;
    t_vdq_flags    f_flags;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;
    logic [DW-1:0] b_lo;
    logic [DW-1:0] b_hi;
    t_vdq_flags    b_flags;

    vdq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_lo       (f_lo),
        .o_hi       (f_hi),
        .o_flags    (f_flags),
        .i_full     (full)
    );

    assign q_in = {f_lo, f_hi, f_flags};

    vdq_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {b_lo, b_hi, b_flags} = q_out;

    vdq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!empty),
        .i_lo        (b_lo),
        .i_hi        (b_hi),
        .i_flags     (b_flags),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/vdq_fifo.sv =====
module vdq_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = vdq_pkg::VDQ_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");

    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_wr == r_rd)) else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/vdq_front.sv =====
module vdq_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  vdq_pkg::t_vdq_in                  i_in_data,
    output logic                              o_in_stall,
    output logic                              o_push,
    output logic [vdq_pkg::VDQ_COORD_BITS:0]  o_lo,
    output logic [vdq_pkg::VDQ_COORD_BITS:0]  o_hi,
    output vdq_pkg::t_vdq_flags               o_flags,
    input  logic                              i_full
);

    import vdq_pkg::*;

    localparam int DW = VDQ_COORD_BITS + 1;

    function automatic logic [DW-1:0] coord(input logic [VDQ_FIELD_BITS-1:0] f);
        logic [VDQ_EXT_BITS-1:0] w;
        w = VDQ_EXT_BITS'(signed'(f));
        return {w[VDQ_COORD_BITS-1], w[VDQ_COORD_BITS-1:0]};
    endfunction

    logic          adv;
    logic          r_s1_valid;
    logic [DW-1:0] r_dx;
    logic [DW-1:0] r_dy;
    logic          r_s2_valid;
    logic [DW-1:0] r_lo;
    logic [DW-1:0] r_hi;
    t_vdq_flags    r_flags;
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    logic          swap;

    assign adv        = !r_s2_valid || !i_full;
    assign o_in_stall = !adv;
    assign o_push     = r_s2_valid && !i_full;

    assign ax   = r_dx[DW-1] ? (~r_dx + 1'b1) : r_dx;
    assign ay   = r_dy[DW-1] ? (~r_dy + 1'b1) : r_dy;
    assign swap = (ay > ax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx          <= coord(i_in_data.end_x) - coord(i_in_data.start_x);
            r_dy          <= coord(i_in_data.end_y) - coord(i_in_data.start_y);
            r_lo          <= swap ? ax : ay;
            r_hi          <= swap ? ay : ax;
            r_flags.zero  <= (r_dx == '0) && (r_dy == '0);
            r_flags.swap  <= swap;
            r_flags.neg_x <= r_dx[DW-1];
            r_flags.neg_y <= r_dy[DW-1];
        end
    end

    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/vdq_back.sv =====
module vdq_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [vdq_pkg::VDQ_COORD_BITS:0]  i_lo,
    input  logic [vdq_pkg::VDQ_COORD_BITS:0]  i_hi,
    input  vdq_pkg::t_vdq_flags               i_flags,
    output logic                              o_pop,
    output logic                              o_out_valid,
    output vdq_pkg::t_vdq_out                 o_out_data,
    input  logic                              i_out_stall
);

    import vdq_pkg::*;

    localparam int DW    = VDQ_COORD_BITS + 1;
    localparam int PW    = DW + VDQ_FRAC_BITS;
    localparam int PAW   = DW + VDQ_HALF_BITS;
    localparam int STEPS = VDQ_SEARCH_STEPS;
    localparam int LASTS = STEPS - 1;

    typedef struct packed {
        logic [DW-1:0]           lo;
        logic [DW-1:0]           hi;
        logic [VDQ_CNT_BITS-1:0] cnt;
        t_vdq_flags              flags;
    } t_srch;

    logic             adv;
    t_srch            stage_in [STEPS];
    logic [STEPS-1:0] stage_in_valid;
    logic [STEPS-1:0] r_a_valid;
    logic [STEPS-1:0] r_a_ok;
    t_srch            r_a [STEPS];
    logic [PAW-1:0]   r_pa [STEPS];
    logic [PAW-1:0]   r_pb [STEPS];
    logic [STEPS-1:0] r_b_valid;
    t_srch            r_b [STEPS];
    logic             r_out_valid;
    t_vdq_out         r_out_data;

    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && i_valid;

    // binary search for the number of thresholds reached, one bit per step
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [VDQ_CNT_BITS-1:0] STEP_BIT = VDQ_CNT_BITS'(1 << (LASTS - s));

        logic [VDQ_CNT_BITS-1:0]  idx;
        logic                     ok;
        logic [VDQ_FRAC_BITS-1:0] th;
        logic [PW-1:0]            prod;
        logic [PW-1:0]            left;
        logic                     ge;
        t_srch                    n_b;

        if (s == 0) begin : g_head
            assign stage_in[s]       = '{lo: i_lo, hi: i_hi, cnt: '0, flags: i_flags};
            assign stage_in_valid[s] = i_valid;
        end else begin : g_link
            assign stage_in[s]       = r_b[s-1];
            assign stage_in_valid[s] = r_b_valid[s-1];
        end

        assign idx = stage_in[s].cnt + STEP_BIT - VDQ_CNT_BITS'(1);
        assign ok  = (idx < VDQ_CNT_BITS'(VDQ_NUM_THRESH));
        assign th  = VDQ_TAN[idx[VDQ_TIDX_BITS-1:0]];

        assign prod = {r_pa[s], VDQ_HALF_BITS'(0)} + PW'(r_pb[s]);
        assign left = {r_a[s].lo, VDQ_FRAC_BITS'(0)};
        assign ge   = r_a_ok[s] && (left >= prod);

        always_comb begin
            n_b     = r_a[s];
            n_b.cnt = ge ? (r_a[s].cnt + STEP_BIT) : r_a[s].cnt;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_valid[s] <= 1'b0;
                r_b_valid[s] <= 1'b0;
            end else if (adv) begin
                r_a_valid[s] <= stage_in_valid[s];
                r_b_valid[s] <= r_a_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_a[s]    <= stage_in[s];
                r_a_ok[s] <= ok;
                r_pa[s]   <= PAW'(stage_in[s].hi) *
                             PAW'(th[VDQ_FRAC_BITS-1:VDQ_HALF_BITS]);
                r_pb[s]   <= PAW'(stage_in[s].hi) * PAW'(th[VDQ_HALF_BITS-1:0]);
                r_b[s]    <= n_b;
            end
        end
    end

    t_srch                    fin;
    logic [VDQ_TURN_BITS-1:0] oct_pos;
    logic [VDQ_TURN_BITS-1:0] turn;
    logic [VDQ_FINE_BITS-1:0] fine;
    logic [VDQ_FINE_BITS-1:0] biased;

    assign fin     = r_b[LASTS];
    assign oct_pos = fin.flags.swap ? (VDQ_OCTANT_STEPS - VDQ_TURN_BITS'(fin.cnt))
                                    : VDQ_TURN_BITS'(fin.cnt);

    // unfold by quadrant
    always_comb begin
        unique case ({fin.flags.neg_x, fin.flags.neg_y})
            2'b00: turn = oct_pos;
            2'b10: turn = VDQ_HALF_TURN - oct_pos;
            2'b11: turn = VDQ_HALF_TURN + oct_pos;
            2'b01: turn = VDQ_FULL_TURN - oct_pos;
        endcase
    end

    assign fine   = fin.flags.zero ? '0 : turn[VDQ_FINE_BITS-1:0];
    assign biased = fine + VDQ_COARSE_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_b_valid[LASTS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data.facing_fine   <= fine;
            r_out_data.facing_coarse <= biased[VDQ_FINE_BITS-1:VDQ_FINE_BITS-VDQ_COARSE_BITS];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_lo <= i_hi)) else $error("octant fold gave lo above hi");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid[LASTS] |-> (fin.cnt <= VDQ_CNT_BITS'(VDQ_NUM_THRESH)))
        else $error("threshold count out of range");

    a_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid[LASTS] && fin.flags.zero) |-> (fin.cnt == VDQ_CNT_BITS'(VDQ_NUM_THRESH)))
        else $error("zero vector did not reach every threshold");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    import vdq_pkg::*;

    localparam int NUM_RANDOM  = 1100;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int NUM_DIRECTED = 11;
    localparam int DIR_DX [NUM_DIRECTED] = '{1, 0, -1, 0, 1000, 65535, 1000, -3, 2, -1, 40000};
    localparam int DIR_DY [NUM_DIRECTED] = '{0, 1, 0, -1, -1, -1, 25, 1, -1, -2, -40000};

    // predicts the fine and coarse facing of each accepted point pair
    class facing_board;
        logic [63:0] tan_q48 [32];
        t_vdq_out    facing_q [$];
        int          errors;

        function new();
            errors = 0;
            build_tan_table();
        endfunction

        function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        // tan((2k+1)*pi/256) from sine and cosine series at q62, then q48 rounded
        function void build_tan_table();
            logic [63:0]  step;
            logic [63:0]  x;
            logic [63:0]  x2;
            logic [63:0]  sin_term;
            logic [63:0]  sin_sum;
            logic [63:0]  cos_term;
            logic [63:0]  cos_sum;
            logic [127:0] quo;
            step = 64'hC90FDAA22168C235 >> 8;
            for (int k = 0; k < 32; k++) begin
                x        = 64'(2 * k + 1) * step;
                x2       = mul_q62(x, x);
                sin_term = x;
                sin_sum  = x;
                cos_term = 64'h4000000000000000;
                cos_sum  = 64'h4000000000000000;
                for (int n = 1; n <= 14; n++) begin
                    sin_term = mul_q62(sin_term, x2) / 64'((2 * n) * (2 * n + 1));
                    cos_term = mul_q62(cos_term, x2) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1) begin
                        sin_sum = sin_sum - sin_term;
                        cos_sum = cos_sum - cos_term;
                    end else begin
                        sin_sum = sin_sum + sin_term;
                        cos_sum = cos_sum + cos_term;
                    end
                end
                quo        = ({64'd0, sin_sum} << 49) / {64'd0, cos_sum};
                tan_q48[k] = (quo[63:0] + 64'd1) >> 1;
            end
        endfunction

        function t_vdq_out quantize_direction(t_vdq_in pts);
            int              dx;
            int              dy;
            longint unsigned ax;
            longint unsigned ay;
            longint unsigned lo;
            longint unsigned hi;
            logic [127:0]    lo_scaled;
            int              steps;
            logic [8:0]      octant;
            logic [8:0]      turn;
            logic [7:0]      biased;
            t_vdq_out        res;
            dx = int'($signed(pts.end_x)) - int'($signed(pts.start_x));
            dy = int'($signed(pts.end_y)) - int'($signed(pts.start_y));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            res = '0;
            if (ax == 0 && ay == 0) begin
                return res;
            end
            lo = (ay > ax) ? ax : ay;
            hi = (ay > ax) ? ay : ax;
            lo_scaled = {64'd0, lo} << 48;
            steps = 0;
            for (int k = 0; k < 32; k++) begin
                if (lo_scaled >= {64'd0, hi} * {64'd0, tan_q48[k]}) begin
                    steps++;
                end
            end
            octant = (ay > ax) ? 9'd64 - 9'(steps) : 9'(steps);
            if (dx >= 0 && dy >= 0) begin
                turn = octant;
            end else if (dx < 0 && dy >= 0) begin
                turn = 9'd128 - octant;
            end else if (dx < 0) begin
                turn = 9'd128 + octant;
            end else begin
                turn = 9'd256 - octant;
            end
            biased = turn[7:0] + 8'd16;
            res.facing_fine   = turn[7:0];
            res.facing_coarse = biased[7:5];
            return res;
        endfunction

        function void note_points(t_vdq_in pts);
            facing_q.insert(facing_q.size(), quantize_direction(pts));
        endfunction

        function void check_facing(t_vdq_out got);
            t_vdq_out want;
            if (facing_q.size() == 0) begin
                $error("result with nothing pending: facing_fine %0d facing_coarse %0d",
                       got.facing_fine, got.facing_coarse);
                errors++;
                return;
            end
            want = facing_q.pop_front();
            if (got.facing_fine !== want.facing_fine) begin
                $error("facing_fine: expected %0d, got %0d", want.facing_fine, got.facing_fine);
                errors++;
            end
            if (got.facing_coarse !== want.facing_coarse) begin
                $error("facing_coarse: expected %0d, got %0d",
                       want.facing_coarse, got.facing_coarse);
                errors++;
            end
        endfunction

        function int pending();
            return facing_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_vdq_in     i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_vdq_out    o_out_data;
    logic        idle_on     = 1'b1;
    int          stuck_cycles = 0;
    facing_board board;

    vector_direction_quantizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_out_stall <= idle_on && ($urandom_range(0, 99) < 6);

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            board.note_points(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_facing(o_out_data);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("tb_top: done, errors");
        $finish;
    end

    // start coordinate such that start + d stays in the 16-bit range
    function automatic int pick_start(int d);
        int lo_b;
        int hi_b;
        lo_b = (d < 0) ? -32768 - d : -32768;
        hi_b = (d < 0) ? 32767 : 32767 - d;
        return lo_b + int'($urandom_range(0, hi_b - lo_b));
    endfunction

    function automatic t_vdq_in place_vector(int dx, int dy);
        t_vdq_in pts;
        int      sx;
        int      sy;
        sx = pick_start(dx);
        sy = pick_start(dy);
        pts.start_x = 16'(sx);
        pts.start_y = 16'(sy);
        pts.end_x   = 16'(sx + dx);
        pts.end_y   = 16'(sy + dy);
        return pts;
    endfunction

    function automatic int scaled_offset();
        int mag;
        mag = int'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // ratio just at or just below a tangent threshold, in a random octant
    function automatic t_vdq_in threshold_vector();
        logic [127:0] prod;
        int           k;
        int           hi;
        int           lo;
        int           ax;
        int           ay;
        k  = $urandom_range(0, 31);
        hi = int'($urandom_range(1, 65535) >> $urandom_range(0, 8));
        if (hi == 0) begin
            hi = 1;
        end
        prod = 128'(hi) * {64'd0, board.tan_q48[k]};
        lo   = int'(prod[79:48]);
        if (prod[47:0] != 0) begin
            lo++;
        end
        lo -= int'($urandom_range(0, 1));
        if (lo < 0) begin
            lo = 0;
        end
        if ($urandom_range(0, 1)) begin
            ax = lo;
            ay = hi;
        end else begin
            ax = hi;
            ay = lo;
        end
        if ($urandom_range(0, 1)) begin
            ax = -ax;
        end
        if ($urandom_range(0, 1)) begin
            ay = -ay;
        end
        return place_vector(ax, ay);
    endfunction

    task automatic send_points(input t_vdq_in pts);
        if (idle_on && $urandom_range(0, 99) < 3) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pts;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int      mode;
        int      dx;
        int      dy;
        t_vdq_in pts;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vectors, full-range diagonals and axes, a small diagonal across zero
        send_points({16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_points({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_points({16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
        send_points({16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
        send_points({16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        send_points({16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        send_points({16'h8000, 16'h1234, 16'h7fff, 16'h1234});
        send_points({16'h5555, 16'h7fff, 16'h5555, 16'h8000});
        send_points({16'hffff, 16'h0000, 16'h0000, 16'hffff});
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_points(place_vector(DIR_DX[i], DIR_DY[i]));
        end
        send_points(threshold_vector());
        send_points(threshold_vector());
        wait_drained();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 350) begin
                idle_on <= 1'b0;
            end
            if (n == 650) begin
                idle_on <= 1'b1;
            end
            if (n == 800) begin
                wait_drained();
            end
            mode = $urandom_range(0, 99);
            if (mode < 35) begin
                pts = {$urandom, $urandom};
            end else if (mode < 60) begin
                pts = threshold_vector();
            end else if (mode < 75) begin
                pts = place_vector(int'($urandom_range(0, 16)) - 8,
                                   int'($urandom_range(0, 16)) - 8);
            end else if (mode < 85) begin
                dx = int'($urandom_range(1, 65535));
                dy = dx;
                case ($urandom_range(0, 2))
                    0: begin
                        dy = dx;
                    end
                    1: begin
                        dy = 0;
                    end
                    default: begin
                        dx = 0;
                    end
                endcase
                if ($urandom_range(0, 1)) begin
                    dx = -dx;
                end
                if ($urandom_range(0, 1)) begin
                    dy = -dy;
                end
                pts = place_vector(dx, dy);
            end else begin
                pts = place_vector(scaled_offset(), scaled_offset());
            end
            send_points(pts);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/vdq_pkg.sv
hw/rtl/vdq_fifo.sv
hw/rtl/vdq_front.sv
hw/rtl/vdq_back.sv
hw/rtl/vector_direction_quantizer_core.sv
sim/tb_top.sv
